FILE: src/dpod_pkg.sv
// Shared types and constants for the date period overlap block.
package dpod_pkg;

    localparam int DATE_W   = 23;
    localparam int YEAR_W   = 14;
    localparam int SERIAL_W = 22;
    localparam int PROD_W   = 27;
    localparam int MUL_B_W  = 13;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for any 14-bit x
    localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
    localparam int                 RECIP_SHIFT = 19;
    localparam logic [MUL_B_W-1:0] CENTURY     = 13'd100;
    localparam logic [SERIAL_W-1:0] CENT_LAST  = 22'd99;
    localparam logic [MUL_B_W-1:0] DAYS_YEAR   = 13'd365;
    localparam logic [YEAR_W-1:0]  MAX_YEAR    = 14'd9999;

    typedef enum logic {
        OP_MUL_ADD,
        OP_ADD_SUB
    } arith_op_t;

    // year in the low bits, matching the stream packing
    typedef struct packed {
        logic [4:0]        day;
        logic [3:0]        month;
        logic [YEAR_W-1:0] year;
    } date_t;

    typedef struct packed {
        logic       valid;
        logic [8:0] offset;  // days before the month plus day of month
    } date_info_t;

endpackage

FILE: src/date_period_overlap_days.sv
// Day overlap of two date periods: sequencer around one shared arithmetic unit.
//
// Input channel (s_): one item carries four dates (first start, first end,
// second start, second end). Result channel (m_): one item per input item
// with the overlap day count, an overlap flag and an invalid-date flag.
// Each date is turned into a serial day number in four steps on the shared
// arithmetic unit: divide year-1 by 100 by reciprocal, century check, year
// product, leap-day correction. The four dates are done one after another,
// then a compare step and a count step follow: m_tvalid rises in the same
// cycle that s_tready returns, so a new item is taken only once the previous
// one is through. s_tready is high only while the sequencer is idle,
// so one item is in work at a time; a new item may be taken while the
// previous result still waits on m_tready. If the receiver stalls, the
// finished count waits in its final step until the output register frees up.
// Reset (aresetn low, synchronous) returns the sequencer to idle and drops
// m_tvalid.
module date_period_overlap_days (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // first_start_year, first_start_month, first_start_day, first_end_year,
    // first_end_month, first_end_day, second_start_year, second_start_month,
    // second_start_day, second_end_year, second_end_month, second_end_day, pad
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // overlap_days, periods_overlap, invalid_date
    output logic [23:0] m_tdata
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_REM,
        ST_MUL,
        ST_ADJ,
        ST_CMP,
        ST_CNT
    } state_t;

    localparam int SW = dpod_pkg::SERIAL_W;

    state_t                state_reg, state_next;
    dpod_pkg::date_t       dates_reg [4];
    dpod_pkg::date_t       dates_next [4];
    logic [1:0]            idx_reg, idx_next;
    logic [7:0]            q_reg, q_next;
    logic                  leap_reg, leap_next;
    logic [SW-1:0]         acc_reg, acc_next;
    logic [SW-1:0]         serial_reg [4];
    logic [SW-1:0]         serial_next [4];
    logic                  bad_reg, bad_next;
    logic [SW-1:0]         lo_reg, lo_next;
    logic [SW-1:0]         hi_reg, hi_next;
    logic                  ok_reg, ok_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [23:0]           m_tdata_reg, m_tdata_next;

    dpod_pkg::date_t       cur;
    logic [dpod_pkg::YEAR_W-1:0] py;
    dpod_pkg::arith_op_t   op;
    logic [dpod_pkg::YEAR_W-1:0] op_a;
    logic [SW-1:0]         op_b, op_c;
    logic [dpod_pkg::PROD_W-1:0] res;
    dpod_pkg::date_info_t  info;
    logic                  cent;

    assign cur = dates_reg[idx_reg];
    assign py  = cur.year - 14'd1;

    dpod_arith u_arith (
        .op  (op),
        .a   (op_a),
        .b   (op_b),
        .c   (op_c),
        .res (res)
    );

    dpod_date_chk u_date_chk (
        .date (cur),
        .leap (leap_reg),
        .info (info)
    );

    // py == 100*q + 99 means the year itself is a century year
    assign cent = (res[dpod_pkg::YEAR_W:0] == {1'b0, py});

    always_comb begin
        op   = dpod_pkg::OP_MUL_ADD;
        op_a = py;
        op_b = '0;
        op_c = '0;
        case (state_reg)
            ST_DIV: begin
                op_b = SW'(dpod_pkg::RECIP_100);
            end
            ST_REM: begin
                op_a = dpod_pkg::YEAR_W'(q_reg);
                op_b = SW'(dpod_pkg::CENTURY);
                op_c = dpod_pkg::CENT_LAST;
            end
            ST_MUL: begin
                op_b = SW'(dpod_pkg::DAYS_YEAR);
                op_c = SW'(py[dpod_pkg::YEAR_W-1:2]) + SW'(info.offset);
            end
            ST_ADJ: begin
                op   = dpod_pkg::OP_ADD_SUB;
                op_a = dpod_pkg::YEAR_W'(q_reg[7:2]);
                op_b = SW'(q_reg);
                op_c = acc_reg;
            end
            ST_CNT: begin
                op   = dpod_pkg::OP_ADD_SUB;
                op_a = dpod_pkg::YEAR_W'(1);
                op_b = lo_reg;
                op_c = hi_reg;
            end
            default: begin
                op = dpod_pkg::OP_MUL_ADD;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        dates_next    = dates_reg;
        idx_next      = idx_reg;
        q_next        = q_reg;
        leap_next     = leap_reg;
        acc_next      = acc_reg;
        serial_next   = serial_reg;
        bad_next      = bad_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    for (int i = 0; i < 4; i++) begin
                        dates_next[i] = s_tdata[dpod_pkg::DATE_W*i +: dpod_pkg::DATE_W];
                    end
                    idx_next   = 2'd0;
                    bad_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                q_next     = res[dpod_pkg::PROD_W-1:dpod_pkg::RECIP_SHIFT];
                state_next = ST_REM;
            end
            ST_REM: begin
                leap_next  = (py[1:0] == 2'd3) && (!cent || (q_reg[1:0] == 2'd3));
                state_next = ST_MUL;
            end
            ST_MUL: begin
                acc_next   = res[SW-1:0];
                bad_next   = bad_reg || !info.valid;
                state_next = ST_ADJ;
            end
            ST_ADJ: begin
                serial_next[idx_reg] = res[SW-1:0];
                idx_next             = idx_reg + 2'd1;
                state_next           = (idx_reg == 2'd3) ? ST_CMP : ST_DIV;
            end
            ST_CMP: begin
                lo_next = (serial_reg[0] > serial_reg[2]) ? serial_reg[0] : serial_reg[2];
                hi_next = (serial_reg[1] < serial_reg[3]) ? serial_reg[1] : serial_reg[3];
                ok_next = !bad_reg && (serial_reg[0] <= serial_reg[1])
                        && (serial_reg[2] <= serial_reg[3]) && (lo_next <= hi_next);
                state_next = ST_CNT;
            end
            ST_CNT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {bad_reg, ok_reg, ok_reg ? res[SW-1:0] : {SW{1'b0}}};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= 2'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        dates_reg   <= dates_next;
        q_reg       <= q_next;
        leap_reg    <= leap_next;
        acc_reg     <= acc_next;
        serial_reg  <= serial_next;
        bad_reg     <= bad_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while sequencer busy");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[23] |-> (m_tdata[22:0] == 23'd0))
        else $error("invalid date with nonzero count");

    a_flag_matches_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[22] == (m_tdata[21:0] != 22'd0)))
        else $error("overlap flag disagrees with count");

    a_result_from_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_CNT))
        else $error("result raised outside count step");
`endif

endmodule

FILE: src/dpod_arith.sv
// Shared multiply-add / add-subtract unit used by the sequencer.
module dpod_arith (
    input  dpod_pkg::arith_op_t              op,
    input  logic [dpod_pkg::YEAR_W-1:0]      a,
    input  logic [dpod_pkg::SERIAL_W-1:0]    b,
    input  logic [dpod_pkg::SERIAL_W-1:0]    c,
    output logic [dpod_pkg::PROD_W-1:0]      res
);

    logic [dpod_pkg::PROD_W-1:0]   prod;
    logic [dpod_pkg::SERIAL_W-1:0] sum;

    assign prod = a * b[dpod_pkg::MUL_B_W-1:0];
    assign sum  = c + dpod_pkg::SERIAL_W'(a) - b;

    always_comb begin
        case (op)
            dpod_pkg::OP_MUL_ADD: res = prod + dpod_pkg::PROD_W'(c);
            dpod_pkg::OP_ADD_SUB: res = dpod_pkg::PROD_W'(sum);
            default:              res = '0;
        endcase
    end

endmodule

FILE: src/dpod_date_chk.sv
// Date validity check and day-of-year offset for one calendar date.
module dpod_date_chk (
    input  dpod_pkg::date_t      date,
    input  logic                 leap,
    output dpod_pkg::date_info_t info
);

    logic [4:0] dim;
    logic [8:0] days_before;

    always_comb begin
        case (date.month)
            4'd1:    begin dim = 5'd31;                 days_before = 9'd0;   end
            4'd2:    begin dim = leap ? 5'd29 : 5'd28;  days_before = 9'd31;  end
            4'd3:    begin dim = 5'd31;                 days_before = 9'd59;  end
            4'd4:    begin dim = 5'd30;                 days_before = 9'd90;  end
            4'd5:    begin dim = 5'd31;                 days_before = 9'd120; end
            4'd6:    begin dim = 5'd30;                 days_before = 9'd151; end
            4'd7:    begin dim = 5'd31;                 days_before = 9'd181; end
            4'd8:    begin dim = 5'd31;                 days_before = 9'd212; end
            4'd9:    begin dim = 5'd30;                 days_before = 9'd243; end
            4'd10:   begin dim = 5'd31;                 days_before = 9'd273; end
            4'd11:   begin dim = 5'd30;                 days_before = 9'd304; end
            4'd12:   begin dim = 5'd31;                 days_before = 9'd334; end
            default: begin dim = 5'd0;                  days_before = 9'd0;   end
        endcase
    end

    // leap day only shifts months after February
    assign info.offset = days_before + 9'(date.day)
                       + ((leap && date.month > 4'd2) ? 9'd1 : 9'd0);
    assign info.valid  = (date.year != '0) && (date.year <= dpod_pkg::MAX_YEAR)
                       && (dim != 5'd0) && (date.day != 5'd0) && (date.day <= dim);

endmodule
